[rtl/irom_pkg.sv]
// Shared types, ASCII codes and the digit-to-letter table for the Roman encoder.
// No dependencies; used by irom_split, irom_emit and integer_to_roman_encoder.
`timescale 1ns / 1ps

package irom_pkg;

  localparam int ValueW  = 12;
  localparam int LetterW = 7;
  localparam int InDataW = 16;
  localparam int OutDataW = 16;

  localparam logic [ValueW-1:0] ValueMax = 12'd3999;

  localparam logic [1:0] PLACE_THOU = 2'd0;
  localparam logic [1:0] PLACE_HUND = 2'd1;
  localparam logic [1:0] PLACE_TENS = 2'd2;
  localparam logic [1:0] PLACE_UNIT = 2'd3;

  localparam logic [LetterW-1:0] ASC_NONE = 7'h00;
  localparam logic [LetterW-1:0] ASC_M = 7'h4D;
  localparam logic [LetterW-1:0] ASC_D = 7'h44;
  localparam logic [LetterW-1:0] ASC_C = 7'h43;
  localparam logic [LetterW-1:0] ASC_L = 7'h4C;
  localparam logic [LetterW-1:0] ASC_X = 7'h58;
  localparam logic [LetterW-1:0] ASC_V = 7'h56;
  localparam logic [LetterW-1:0] ASC_I = 7'h49;

  // index 0 is the thousands place
  localparam logic [3:0][LetterW-1:0] ONE_SYM  = {ASC_I, ASC_X, ASC_C, ASC_M};
  localparam logic [3:0][LetterW-1:0] FIVE_SYM = {ASC_V, ASC_L, ASC_D, ASC_NONE};
  localparam logic [3:0][LetterW-1:0] TEN_SYM  = {ASC_X, ASC_C, ASC_M, ASC_NONE};

  typedef struct packed {
    logic       oor;
    logic       zero;
    logic [1:0] thou;
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] unit;
  } digits_t;

  typedef struct packed {
    logic [2:0]               len;
    logic [3:0][LetterW-1:0]  sym;
  } sym_group_t;

  function automatic sym_group_t digit_letters(input logic [1:0] place,
                                               input logic [3:0] d);
    sym_group_t g;
    logic [LetterW-1:0] one;
    logic [LetterW-1:0] five;
    logic [LetterW-1:0] ten;
    one  = ONE_SYM[place];
    five = FIVE_SYM[place];
    ten  = TEN_SYM[place];
    g.len = 3'd0;
    g.sym = {4{one}};
    if (place == PLACE_THOU) begin
      g.len = (d > 4'd3) ? 3'd3 : d[2:0];
    end else begin
      case (d)
        4'd0, 4'd1, 4'd2, 4'd3: begin
          g.len = d[2:0];
        end
        4'd4: begin
          g.len    = 3'd2;
          g.sym[1] = five;
        end
        4'd5, 4'd6, 4'd7, 4'd8: begin
          g.len    = 3'(d - 4'd4);
          g.sym[0] = five;
        end
        4'd9: begin
          g.len    = 3'd2;
          g.sym[1] = ten;
        end
        default: begin
          g.len = 3'd0;
        end
      endcase
    end
    return g;
  endfunction

endpackage

[rtl/irom_split.sv]
// Three-stage pipeline that splits a value into thousands, hundreds, tens and units.
// Depends on irom_pkg for digits_t and the range limit.
`timescale 1ns / 1ps

module irom_split
  import irom_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ValueW-1:0] in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output digits_t           out_digits
);

  logic             s1_valid;
  logic             s1_oor;
  logic             s1_zero;
  logic [1:0]       s1_thou;
  logic [9:0]       s1_rem;

  logic             s2_valid;
  logic             s2_oor;
  logic             s2_zero;
  logic [1:0]       s2_thou;
  logic [3:0]       s2_hund;
  logic [6:0]       s2_rem;

  logic             s3_valid;
  digits_t          s3_digits;

  logic             rdy1;
  logic             rdy2;
  logic             rdy3;

  logic [1:0]       thou_next;
  logic [9:0]       rem1_next;
  logic [3:0]       hund_next;
  logic [6:0]       rem2_next;
  logic [3:0]       tens_next;
  logic [3:0]       unit_next;

  assign rdy3     = !s3_valid || out_ready;
  assign rdy2     = !s2_valid || rdy3;
  assign rdy1     = !s1_valid || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    if (in_value >= 12'd3000) begin
      thou_next = 2'd3;
    end else if (in_value >= 12'd2000) begin
      thou_next = 2'd2;
    end else if (in_value >= 12'd1000) begin
      thou_next = 2'd1;
    end else begin
      thou_next = 2'd0;
    end
    rem1_next = 10'(in_value - 12'(thou_next) * 12'd1000);
  end

  always_comb begin
    hund_next = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (s1_rem >= 10'(i * 100)) begin
        hund_next = 4'(i);
      end
    end
    rem2_next = 7'(s1_rem - 10'(hund_next) * 10'd100);
  end

  always_comb begin
    tens_next = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (s2_rem >= 7'(i * 10)) begin
        tens_next = 4'(i);
      end
    end
    unit_next = 4'(s2_rem - 7'(tens_next) * 7'd10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_valid <= in_valid;
      end
      if (rdy2) begin
        s2_valid <= s1_valid;
      end
      if (rdy3) begin
        s3_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_oor  <= in_value > ValueMax;
      s1_zero <= in_value == '0;
      s1_thou <= thou_next;
      s1_rem  <= rem1_next;
    end
    if (rdy2) begin
      s2_oor  <= s1_oor;
      s2_zero <= s1_zero;
      s2_thou <= s1_thou;
      s2_hund <= hund_next;
      s2_rem  <= rem2_next;
    end
    if (rdy3) begin
      s3_digits.oor  <= s2_oor;
      s3_digits.zero <= s2_zero;
      s3_digits.thou <= s2_thou;
      s3_digits.hund <= s2_hund;
      s3_digits.tens <= tens_next;
      s3_digits.unit <= unit_next;
    end
  end

  assign out_valid  = s3_valid;
  assign out_digits = s3_digits;

endmodule

[rtl/irom_emit.sv]
// Letter stage: turns four digits into letter groups and sends one letter per word.
// Depends on irom_pkg for digits_t, sym_group_t and digit_letters.
`timescale 1ns / 1ps

module irom_emit
  import irom_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  digits_t            in_digits,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LetterW-1:0] out_letter,
  output logic               out_letter_valid,
  output logic               out_oor,
  output logic               out_last
);

  logic                   busy;
  logic                   special;
  logic                   oor;
  sym_group_t [3:0]       grp;
  logic [1:0]             p;
  logic [1:0]             k;

  sym_group_t [3:0]       load_grp;
  logic [1:0]             load_p;
  sym_group_t             cur;
  logic                   at_end;
  logic                   later;
  logic [1:0]             p_next;
  logic                   last;
  logic                   load;
  logic                   step;

  always_comb begin
    load_grp[PLACE_THOU] = digit_letters(PLACE_THOU, {2'b00, in_digits.thou});
    load_grp[PLACE_HUND] = digit_letters(PLACE_HUND, in_digits.hund);
    load_grp[PLACE_TENS] = digit_letters(PLACE_TENS, in_digits.tens);
    load_grp[PLACE_UNIT] = digit_letters(PLACE_UNIT, in_digits.unit);
    load_p = PLACE_UNIT;
    for (int i = 3; i >= 0; i--) begin
      if (load_grp[i].len != 3'd0) begin
        load_p = 2'(i);
      end
    end
  end

  always_comb begin
    cur    = grp[p];
    at_end = ({1'b0, k} == cur.len - 3'd1);
    later  = 1'b0;
    p_next = p;
    for (int i = 3; i >= 0; i--) begin
      if (2'(i) > p && grp[i].len != 3'd0) begin
        later  = 1'b1;
        p_next = 2'(i);
      end
    end
    last = special || (at_end && !later);
  end

  assign in_ready = !busy || (out_ready && last);
  assign load     = in_valid && in_ready;
  assign step     = busy && out_ready && !last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (busy && out_ready && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      special <= in_digits.oor || in_digits.zero;
      oor     <= in_digits.oor;
      grp     <= load_grp;
      p       <= load_p;
      k       <= 2'd0;
    end else if (step) begin
      if (at_end) begin
        p <= p_next;
        k <= 2'd0;
      end else begin
        k <= k + 2'd1;
      end
    end
  end

  assign out_valid        = busy;
  assign out_letter       = special ? ASC_NONE : cur.sym[k];
  assign out_letter_valid = !special;
  assign out_oor          = special && oor;
  assign out_last         = last;

endmodule

[rtl/integer_to_roman_encoder.sv]
// Top level of the integer to Roman numeral encoder.
// Depends on irom_pkg, irom_split and irom_emit.
`timescale 1ns / 1ps

// Each input word carries a value from 0 to 3999; the block answers with its
// Roman numeral, one ASCII letter (M D C L X V I) per output word, tlast on the
// final letter. Zero gives one word with no letter; a value above 3999 gives
// one word with no letter and the out-of-range bit set. A value passes a
// three-stage digit split (stage registers s1, s2, s3) and then the letter
// stage, which loads it into its own registers before the first letter
// appears. The letter stage sends one letter per cycle while m_tready is
// high, so a value occupies the output for 1 to 15 words; the input is
// accepted back to back as long as the output keeps up, and the next value
// loads in the cycle its predecessor's last letter is taken.

module integer_to_roman_encoder
  import irom_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [InDataW-1:0]  s_tdata,   // [11:0] value
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // [6:0] letter, [7] letter_valid, [8] out_of_range
  output logic                m_tlast
);

  logic               split_valid;
  logic               split_ready;
  digits_t            split_digits;
  logic [LetterW-1:0] letter;
  logic               letter_valid;
  logic               out_of_range;

  irom_split u_split (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_value   (s_tdata[ValueW-1:0]),
    .out_valid  (split_valid),
    .out_ready  (split_ready),
    .out_digits (split_digits)
  );

  irom_emit u_emit (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (split_valid),
    .in_ready         (split_ready),
    .in_digits        (split_digits),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .out_letter       (letter),
    .out_letter_valid (letter_valid),
    .out_oor          (out_of_range),
    .out_last         (m_tlast)
  );

  assign m_tdata = {{(OutDataW - LetterW - 2){1'b0}}, out_of_range, letter_valid, letter};

endmodule

[bench/tb_top.sv]
// Self-checking bench for integer_to_roman_encoder: directed and random values in,
// letters checked word by word against an in-bench numeral predictor.
// Depends on irom_pkg and the encoder RTL.
`timescale 1ns / 1ps

module tb_top;
  import irom_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int RandomItems = 330;
  localparam int SettleCycles = 24;

  typedef struct packed {
    logic [LetterW-1:0] letter;
    logic               letter_valid;
    logic               oor;
    logic               last;
  } numeral_word_t;

  typedef struct {
    logic [ValueW-1:0] value;
    int unsigned       gap;
    bit                drain;
  } value_req_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tlast;

  value_req_t    value_q[$];
  numeral_word_t letters_due[$];
  int            letters_open = 0;
  int unsigned   tx_wait = 0;
  int unsigned   rx_stall = 0;
  int unsigned   rx_count = 0;
  bit            rx_calm = 1'b0;
  int            errors = 0;
  int unsigned   cycles = 0;

  integer_to_roman_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  task automatic predict_numeral(input logic [ValueW-1:0] v);
    logic [LetterW-1:0] seq[$];
    logic [LetterW-1:0] one;
    logic [LetterW-1:0] five;
    logic [LetterW-1:0] ten;
    int rest;
    int scale;
    int d;
    if (v > ValueMax) begin
      letters_due.push_back('{ASC_NONE, 1'b0, 1'b1, 1'b1});
    end else if (v == '0) begin
      letters_due.push_back('{ASC_NONE, 1'b0, 1'b0, 1'b1});
    end else begin
      rest = int'(v);
      for (int p = 0; p < 4; p++) begin
        case (p)
          PLACE_THOU: begin
            scale = 1000; one = ASC_M; five = ASC_NONE; ten = ASC_NONE;
          end
          PLACE_HUND: begin
            scale = 100; one = ASC_C; five = ASC_D; ten = ASC_M;
          end
          PLACE_TENS: begin
            scale = 10; one = ASC_X; five = ASC_L; ten = ASC_C;
          end
          default: begin
            scale = 1; one = ASC_I; five = ASC_V; ten = ASC_X;
          end
        endcase
        d = rest / scale;
        rest = rest % scale;
        if (p == PLACE_THOU) begin
          for (int k = 0; k < d; k++) seq.push_back(one);
        end else if (d == 9) begin
          seq.push_back(one);
          seq.push_back(ten);
        end else if (d == 4) begin
          seq.push_back(one);
          seq.push_back(five);
        end else begin
          if (d >= 5) begin
            seq.push_back(five);
            d = d - 5;
          end
          for (int k = 0; k < d; k++) seq.push_back(one);
        end
      end
      for (int i = 0; i < seq.size(); i++)
        letters_due.push_back('{seq[i], 1'b1, 1'b0, (i == seq.size() - 1)});
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
               $time, name, want, want, got, got);
    end
  endtask

  // driver: present the next value once its idle gap has run out and, for a drain item, once no letters are due
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (tx_wait > 0) begin
        s_tvalid <= 1'b0;
        tx_wait <= tx_wait - 1;
      end else if (value_q.size() > 0 &&
                   (!value_q[0].drain || (letters_open == 0 && !(s_tvalid && s_tready)))) begin
        s_tvalid <= 1'b1;
        s_tdata <= {{(InDataW - ValueW){1'b0}}, value_q[0].value};
        tx_wait <= value_q[0].gap;
        void'(value_q.pop_front());
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: after each word, drop m_tready for a random stall, except in calm phases
  always @(posedge clk) begin
    int unsigned n;
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall <= 0;
    end else if (m_tvalid && m_tready) begin
      n = rx_calm ? 0 : $urandom_range(0, 7);
      rx_stall <= n;
      m_tready <= (n == 0);
      rx_count <= rx_count + 1;
      if (rx_count % 40 == 39) rx_calm <= ($urandom_range(0, 2) == 0);
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      m_tready <= (rx_stall == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor: check output words first, then queue the letters of an accepted value
  always @(posedge clk) begin
    numeral_word_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (letters_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual data 0x%0h last %0b",
                   $time, m_tdata, m_tlast);
        end else begin
          want = letters_due.pop_front();
          check_field("letter", int'(want.letter), int'(m_tdata[LetterW-1:0]));
          check_field("letter_valid", int'(want.letter_valid), int'(m_tdata[LetterW]));
          check_field("out_of_range", int'(want.oor), int'(m_tdata[LetterW+1]));
          check_field("last", int'(want.last), int'(m_tlast));
        end
      end
      if (s_tvalid && s_tready) predict_numeral(s_tdata[ValueW-1:0]);
      letters_open <= letters_due.size();
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("integer_to_roman_encoder verification failed");
      $finish;
    end
  end

  initial begin
    value_req_t item;
    int directed[$];
    int r;
    bit tx_calm;
    directed = '{0, 1, 4095, 3999, 4000, 3888, 4, 9, 5, 8, 40, 90, 400, 900,
                 444, 999, 1994, 3000, 500, 50, 14, 2048, 1365, 2730};
    foreach (directed[i]) begin
      item.value = ValueW'(directed[i]);
      item.gap = $urandom_range(0, 7);
      item.drain = (directed[i] == 3888);
      value_q.push_back(item);
    end
    tx_calm = 1'b0;
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 40 == 0) tx_calm = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 19);
      if (r == 0)
        item.value = '0;
      else if (r <= 2)
        item.value = ValueW'($urandom_range(4000, 4095));
      else if (r <= 10)
        item.value = ValueW'($urandom_range(0, 3) * 1000 + $urandom_range(0, 9) * 100 +
                             $urandom_range(0, 9) * 10 + $urandom_range(0, 9));
      else
        item.value = ValueW'($urandom_range(1, 3999));
      item.gap = tx_calm ? 0 : $urandom_range(0, 7);
      item.drain = ($urandom_range(0, 49) == 0);
      value_q.push_back(item);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (value_q.size() > 0 || s_tvalid) @(posedge clk);
    while (letters_due.size() > 0 || letters_open != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    if (errors == 0 && letters_due.size() == 0) begin
      $display("integer_to_roman_encoder verification clean");
    end else begin
      $display("integer_to_roman_encoder verification failed");
    end
    $finish;
  end

endmodule
